FILE: rtl/ovn_pkg.sv
`timescale 1ns / 1ps
package ovn_pkg;

  localparam int TBL_SIZE   = 128;
  localparam int TBL_AW     = $clog2(TBL_SIZE);
  localparam int MAX_OCT    = TBL_AW + 1;
  localparam int OCT_W      = $clog2(MAX_OCT);
  localparam int PITCH_W    = TBL_AW + 1;

  localparam int POS_W      = 7;
  localparam int SEED_W     = 16;
  localparam int CNT_W      = 4;
  localparam int BIAS_W     = 12;
  localparam int BIAS_FRAC  = 8;

  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;

  localparam int W_W        = 32;
  localparam logic [W_W-1:0] W_ONE = W_W'(65536);
  localparam int WDIV_W     = W_W + BIAS_FRAC;
  localparam int WDIV_CNT_W = $clog2(WDIV_W);

  localparam int BLSUM_W    = PITCH_W + SEED_W + 1;
  localparam int PROD_W     = SEED_W + W_W;
  localparam int N_W        = PROD_W + OCT_W;
  localparam int ACC_W      = W_W + OCT_W;
  localparam int Q_W        = SEED_W;
  localparam int DIV_CNT_W  = $clog2(Q_W);

  localparam logic [CNT_W-1:0]  DEF_OCT_COUNT = CNT_W'(8);
  localparam logic [BIAS_W-1:0] DEF_BIAS      = BIAS_W'(512);

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BIAS   = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

endpackage

FILE: rtl/ovn_stream_if.sv
`timescale 1ns / 1ps
interface ovn_in_if;
  import ovn_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [POS_W-1:0]  position;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, output mode, output position, output seed_value,
                  input ready);
  modport sink (input valid, input mode, input position, input seed_value,
                output ready);
endinterface

interface ovn_out_if;
  import ovn_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  query_position;
  logic [SEED_W-1:0] noise_value;

  modport source (output valid, output query_position, output noise_value,
                  input ready);
  modport sink (input valid, input query_position, input noise_value,
                output ready);
endinterface

FILE: rtl/octave_value_noise_1d_top.sv
`timescale 1ns / 1ps
// One-dimensional octave value noise over a 128-entry seed memory (Q0.16). A write
// item (mode 0) stores a seed. A query item (mode 1) runs k octaves,
// k being octave_count clamped to 1..8: one octave a cycle reads the two neighbor
// seeds from the dual-read seed memory, blends them, weights the blend and
// accumulates, then a bit-serial divider normalizes the sum, and the next item is
// taken once the result sits in the output register. The octave weights live in a
// small table whose entries 1..7 are rebuilt by a serial divider after reset and
// after every scale_bias write; while the rebuild runs no item is taken.
// The seed memory reads as zeros after reset through per-entry valid bits, so
// there is no clearing pass.
module octave_value_noise_1d_top (
  input  logic                            clk,
  input  logic                            rst_n,
  ovn_in_if.sink                          in_ch,
  ovn_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ovn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ovn_pkg::CFG_W-1:0]       cfg_wdata
);
  import ovn_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_FIN} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    oct_cnt_r;
  logic [BIAS_W-1:0]   bias_r;

  logic [TBL_AW-1:0]   x_r;
  logic [POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]    k_r;
  logic [CNT_W-1:0]    iss_r;

  logic [SEED_W-1:0]   seed_mem [TBL_SIZE];
  logic [TBL_SIZE-1:0] vld_r;
  logic [SEED_W-1:0]   rd_a_r, rd_b_r;
  logic                rd_a_ok_r, rd_b_ok_r;

  logic                s1_v_r;
  logic [OCT_W-1:0]    s1_o_r, s1_sh_r;
  logic [TBL_AW-1:0]   s1_d_r;
  logic                s2_v_r;
  logic [SEED_W-1:0]   blend_r;
  logic [W_W-1:0]      w_r;
  logic                s3_v_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]    acc_r;
  logic [N_W-1:0]      n_r;

  logic [N_W-1:0]      rem_r, dsh_r;
  logic [Q_W-1:0]      q_r;
  logic [DIV_CNT_W-1:0] dcnt_r;

  logic                out_v_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [SEED_W-1:0]   out_noise_r;

  logic                wbusy_r;
  logic [OCT_W-1:0]    widx_r;
  logic [WDIV_CNT_W-1:0] wcnt_r;
  logic [WDIV_W-1:0]   wdvd_r, wquo_r;
  logic [BIAS_W-1:0]   wrem_r;
  logic [W_W-1:0]      wtab_r [MAX_OCT];

  logic                in_acc, wr_en, q_start, issue, run_done, bias_wr;
  logic [CNT_W-1:0]    k_sel;
  logic [OCT_W-1:0]    iss_o, sh;
  logic [PITCH_W-1:0]  pitch, s1_pitch, p1;
  logic [TBL_AW-1:0]   s1a, s2a, d_off;
  logic [SEED_W-1:0]   seed_a, seed_b;
  logic [BLSUM_W-1:0]  blsum;
  logic                div_ge;
  logic [BIAS_W:0]     wrem2;
  logic [BIAS_W-1:0]   bdiv;
  logic                wge, wlast;
  logic [WDIV_W-1:0]   wq_fin;
  logic [W_W-1:0]      wsat;

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE) && !wbusy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_en       = in_acc && (in_ch.mode == MODE_WRITE);
  assign q_start     = in_acc && (in_ch.mode == MODE_QUERY);
  assign bias_wr     = cfg_we && (cfg_index == CFG_SCALE_BIAS);

  assign out_ch.valid          = out_v_r;
  assign out_ch.query_position = out_pos_r;
  assign out_ch.noise_value    = out_noise_r;

  always_comb begin
    if (oct_cnt_r == '0) begin
      k_sel = CNT_W'(1);
    end else if (oct_cnt_r > CNT_W'(MAX_OCT)) begin
      k_sel = CNT_W'(MAX_OCT);
    end else begin
      k_sel = oct_cnt_r;
    end
  end

  // octave address generation
  assign issue    = (state_r == ST_RUN) && (iss_r < k_r);
  assign iss_o    = iss_r[OCT_W-1:0];
  assign sh       = OCT_W'(TBL_AW) - iss_o;
  assign s1a      = (x_r >> sh) << sh;
  assign pitch    = PITCH_W'(1) << sh;
  assign s2a      = s1a + pitch[TBL_AW-1:0];
  assign d_off    = x_r - s1a;
  assign run_done = (state_r == ST_RUN) && (iss_r == k_r) && !s1_v_r && !s2_v_r && !s3_v_r;

  // blend of the two neighbor seeds
  assign seed_a   = rd_a_ok_r ? rd_a_r : '0;
  assign seed_b   = rd_b_ok_r ? rd_b_r : '0;
  assign s1_pitch = PITCH_W'(1) << s1_sh_r;
  assign p1       = s1_pitch - PITCH_W'(s1_d_r);
  assign blsum    = BLSUM_W'(p1) * BLSUM_W'(seed_a) + BLSUM_W'(s1_d_r) * BLSUM_W'(seed_b);

  assign div_ge   = rem_r >= dsh_r;

  // weight divider step
  assign bdiv   = (bias_r == '0) ? BIAS_W'(1) : bias_r;
  assign wrem2  = {wrem_r, wdvd_r[WDIV_W-1]};
  assign wge    = wrem2 >= {1'b0, bdiv};
  assign wlast  = wcnt_r == WDIV_CNT_W'(WDIV_W - 1);
  assign wq_fin = {wquo_r[WDIV_W-2:0], wge};
  assign wsat   = (|wq_fin[WDIV_W-1:W_W]) ? '1 : wq_fin[W_W-1:0];

  // seed memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seed_mem[in_ch.position[TBL_AW-1:0]] <= in_ch.seed_value;
    end
    if (issue) begin
      rd_a_r    <= seed_mem[s1a];
      rd_b_r    <= seed_mem[s2a];
      rd_a_ok_r <= vld_r[s1a];
      rd_b_ok_r <= vld_r[s2a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[in_ch.position[TBL_AW-1:0]] <= 1'b1;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= DEF_OCT_COUNT;
      bias_r    <= DEF_BIAS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCTAVE_COUNT: oct_cnt_r <= cfg_wdata[CNT_W-1:0];
        CFG_SCALE_BIAS:   bias_r    <= cfg_wdata[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // weight table rebuild
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbusy_r <= 1'b1;
      widx_r  <= OCT_W'(1);
      wcnt_r  <= '0;
      wrem_r  <= '0;
      wdvd_r  <= WDIV_W'(W_ONE) << BIAS_FRAC;
    end else if (bias_wr) begin
      wbusy_r <= 1'b1;
      widx_r  <= OCT_W'(1);
      wcnt_r  <= '0;
      wrem_r  <= '0;
      wdvd_r  <= WDIV_W'(W_ONE) << BIAS_FRAC;
    end else if (wbusy_r) begin
      if (wlast) begin
        wcnt_r <= '0;
        wrem_r <= '0;
        wdvd_r <= WDIV_W'(wsat) << BIAS_FRAC;
        if (widx_r == OCT_W'(MAX_OCT - 1)) begin
          wbusy_r <= 1'b0;
        end else begin
          widx_r <= widx_r + OCT_W'(1);
        end
      end else begin
        wcnt_r <= wcnt_r + WDIV_CNT_W'(1);
        wrem_r <= wge ? BIAS_W'(wrem2 - {1'b0, bdiv}) : wrem2[BIAS_W-1:0];
        wdvd_r <= wdvd_r << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wquo_r    <= wq_fin;
    wtab_r[0] <= W_ONE;
    if (wbusy_r && wlast && !bias_wr) begin
      wtab_r[widx_r] <= wsat;
    end
  end

  // octave pipeline data
  always_ff @(posedge clk) begin
    if (q_start) begin
      x_r   <= in_ch.position[TBL_AW-1:0];
      pos_r <= in_ch.position;
      k_r   <= k_sel;
      acc_r <= '0;
      n_r   <= '0;
    end
    if (issue) begin
      s1_o_r  <= iss_o;
      s1_sh_r <= sh;
      s1_d_r  <= d_off;
    end
    if (s1_v_r) begin
      blend_r <= SEED_W'(blsum >> s1_sh_r);
      w_r     <= wtab_r[s1_o_r];
    end
    if (s2_v_r) begin
      prod_r <= PROD_W'(blend_r) * PROD_W'(w_r);
      acc_r  <= acc_r + ACC_W'(w_r);
    end
    if (s3_v_r) begin
      n_r <= n_r + N_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      iss_r  <= '0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (q_start) begin
        iss_r <= '0;
      end else if (issue) begin
        iss_r <= iss_r + CNT_W'(1);
      end
    end
  end

  // normalizing divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (run_done) begin
      rem_r  <= n_r;
      dsh_r  <= N_W'(acc_r) << (Q_W - 1);
      dcnt_r <= DIV_CNT_W'(Q_W - 1);
    end else if (state_r == ST_DIV) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r  <= dsh_r >> 1;
      q_r    <= {q_r[Q_W-2:0], div_ge};
      dcnt_r <= dcnt_r - DIV_CNT_W'(1);
    end
  end

  // control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_start) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (run_done) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt_r == '0) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_v_r || out_ch.ready) begin
            out_v_r     <= 1'b1;
            out_pos_r   <= pos_r;
            out_noise_r <= q_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
